### sv/ema_pkg.sv
// Shared types and constants for the SMA-seeded moving average block.
package ema_pkg;

  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned PERIOD_W = 7;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd12;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SMA  = 5'b00010,
    ST_DIFF = 5'b00100,
    ST_STEP = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### sv/ema_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module ema_div #(
  parameter int unsigned DW = 38,
  parameter int unsigned VW = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DW-1:0]        dividend_i,
  input  logic [VW-1:0]        divisor_i,
  output logic [DW-1:0]        quot_o,
  output ema_pkg::div_stat_t   stat_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [VW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] dvs_q;
  logic [VW:0]   trial;
  logic          ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    if (ge) begin
      rem_d = VW'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[VW-1:0];
    end
    quo_d = {quo_q[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o      = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### sv/ema_sma_seeded_top.sv
// Top level of the SMA-seeded exponential moving average of closing prices.
//
// Input channel (in_valid_i/in_ready_o): one closing price in unsigned Q16.16
// plus a restart flag per transfer. Output channel (out_valid_o/out_ready_i):
// one result per input, ema_value_o with valid_res_o; ema_value_o is zero
// while valid_res_o is low. Configuration channel (cfg_valid_i/cfg_ready_o)
// writes the period; it is always ready and should only be written while idle.
// One item is handled at a time; in_ready_o is high only when idle.
// Steps per item, with a divider PRICE_BITS + clog2(MAX_PERIOD+1) bits wide:
//   summing items: from the input transfer straight to the result register;
//   smoothed items: one pass of the divider;
//   the seeding item: two passes of the divider (mean, then smoothing step).
// With the defaults the divider is 39 bits wide. The shared radix-2 divider sets the pace.
// The result register frees the next input while a result waits; a stalled
// receiver holds the block in its final step until the register drains.
// Reset clears the series state and sets the period to 12.
module ema_sma_seeded_top #(
  parameter int unsigned MAX_PERIOD = 64,
  parameter int unsigned PRICE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ema_pkg::PERIOD_W-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ema_pkg::FIELD_W-1:0]      close_price_i,
  input  logic                             restart_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ema_pkg::FIELD_W-1:0]      ema_value_o,
  output logic                             valid_res_o
);

  localparam int unsigned VW = $clog2(MAX_PERIOD + 2);
  localparam int unsigned SW = PRICE_BITS + $clog2(MAX_PERIOD + 1);

  ema_pkg::state_e st_q;
  logic [ema_pkg::PERIOD_W-1:0] period_q;
  logic [SW-1:0]         sum_q;
  logic [VW-1:0]         cnt_q;
  logic                  seeded_q;
  logic [PRICE_BITS-1:0] last_q;
  logic [PRICE_BITS-1:0] price_q, base_q, res_q;
  logic [VW-1:0]         den_q;
  logic                  up_q, res_vld_q;
  logic                  out_valid_q, vres_q;
  logic [ema_pkg::FIELD_W-1:0] ema_q;

  logic [VW-1:0]         p_eff, cnt_eff;
  logic                  seeded_eff, seed_now, accept, out_free;
  logic [PRICE_BITS-1:0] price_in, diff, quot_p, step_res;
  logic                  up;
  logic                  div_start;
  logic [SW-1:0]         div_dividend, div_quot;
  logic [VW-1:0]         div_divisor;
  ema_pkg::div_stat_t    div_stat;

  always_comb begin
    if (period_q == '0) begin
      p_eff = VW'(1);
    end else if (32'(period_q) > MAX_PERIOD) begin
      p_eff = VW'(MAX_PERIOD);
    end else begin
      p_eff = VW'(period_q);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == ema_pkg::ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign price_in    = PRICE_BITS'(close_price_i);
  assign cnt_eff     = restart_i ? '0 : cnt_q;
  assign seeded_eff  = restart_i ? 1'b0 : seeded_q;
  assign seed_now    = (cnt_eff >= p_eff) && (cnt_eff != '0);

  assign up       = price_q >= base_q;
  assign diff     = up ? (price_q - base_q) : (base_q - price_q);
  assign quot_p   = div_quot[PRICE_BITS-1:0];
  assign step_res = up_q ? (base_q + quot_p) : (base_q - quot_p);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = sum_q;
    div_divisor  = cnt_q;
    if (accept && !seeded_eff && seed_now) begin
      div_start = 1'b1;
    end else if (st_q == ema_pkg::ST_DIFF) begin
      div_start    = 1'b1;
      div_dividend = SW'({diff, 1'b0});
      div_divisor  = den_q;
    end
  end

  ema_div #(
    .DW(SW),
    .VW(VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .stat_o     (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ema_pkg::ST_IDLE;
      period_q    <= ema_pkg::PERIOD_RESET;
      sum_q       <= '0;
      cnt_q       <= '0;
      seeded_q    <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        period_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i && !(st_q == ema_pkg::ST_OUT && out_free)) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        ema_pkg::ST_IDLE: begin
          if (accept) begin
            if (restart_i) begin
              seeded_q <= 1'b0;
              last_q   <= '0;
            end
            if (seeded_eff) begin
              st_q <= ema_pkg::ST_DIFF;
            end else if (seed_now) begin
              st_q <= ema_pkg::ST_SMA;
            end else begin
              sum_q <= (restart_i ? '0 : sum_q) + SW'(price_in);
              cnt_q <= cnt_eff + 1'b1;
              st_q  <= ema_pkg::ST_OUT;
            end
          end
        end
        ema_pkg::ST_SMA: begin
          if (div_stat.done) begin
            st_q <= ema_pkg::ST_DIFF;
          end
        end
        ema_pkg::ST_DIFF: begin
          st_q <= ema_pkg::ST_STEP;
        end
        ema_pkg::ST_STEP: begin
          if (div_stat.done) begin
            last_q   <= step_res;
            seeded_q <= 1'b1;
            st_q     <= ema_pkg::ST_OUT;
          end
        end
        ema_pkg::ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            st_q        <= ema_pkg::ST_IDLE;
          end
        end
        default: begin
          st_q <= ema_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      price_q   <= price_in;
      base_q    <= restart_i ? '0 : last_q;
      den_q     <= p_eff + 1'b1;
      res_q     <= '0;
      res_vld_q <= 1'b0;
    end
    if (st_q == ema_pkg::ST_SMA && div_stat.done) begin
      base_q <= quot_p;
    end
    if (st_q == ema_pkg::ST_DIFF) begin
      up_q <= up;
    end
    if (st_q == ema_pkg::ST_STEP && div_stat.done) begin
      res_q     <= step_res;
      res_vld_q <= 1'b1;
    end
    if (st_q == ema_pkg::ST_OUT && out_free) begin
      ema_q  <= ema_pkg::FIELD_W'(res_q);
      vres_q <= res_vld_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ema_value_o = ema_q;
  assign valid_res_o = vres_q;

endmodule

### sim/tb_top.sv
// Self-checking testbench for ema_sma_seeded_top against a moving-average predictor.
module tb_top;

  localparam int unsigned FIELD_W  = ema_pkg::FIELD_W;
  localparam int unsigned PERIOD_W = ema_pkg::PERIOD_W;
  localparam int unsigned MAX_P   = 64;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned N_ITEMS = 900;

  typedef struct packed {
    logic [FIELD_W-1:0] price;
    logic               restart;
  } price_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               avail;
  } ema_res_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [PERIOD_W-1:0] cfg_data_i    = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [FIELD_W-1:0]  close_price_i = '0;
  logic                restart_i     = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [FIELD_W-1:0]  ema_value_o;
  logic                valid_res_o;

  price_item_t price_q[$];
  ema_res_t    ema_due_q[$];
  int          err_count = 0;
  int          idle_pct  = 33;

  // predictor state
  logic [PERIOD_W-1:0] period_reg = ema_pkg::PERIOD_RESET;
  logic [37:0]         seed_acc   = '0;
  logic [6:0]          seen_cnt   = '0;
  logic                avg_seeded = 1'b0;
  logic [FIELD_W-1:0]  last_avg   = '0;

  ema_sma_seeded_top #(
    .MAX_PERIOD(MAX_P),
    .PRICE_BITS(PRICE_W)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .close_price_i (close_price_i),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ema_value_o   (ema_value_o),
    .valid_res_o   (valid_res_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned smoothing_period();
    if (period_reg == '0) return 1;
    if (period_reg > MAX_P) return MAX_P;
    return int'(period_reg);
  endfunction

  // base + (price - base) * 2 / (p + 1), truncated toward zero
  function automatic logic [FIELD_W-1:0] smoothed(input logic [FIELD_W-1:0] base,
                                                  input logic [FIELD_W-1:0] price,
                                                  input int unsigned p);
    logic [63:0] step;
    if (price >= base) begin
      step = ({32'd0, price} - {32'd0, base}) * 64'd2 / 64'(p + 1);
      return base + step[FIELD_W-1:0];
    end
    step = ({32'd0, base} - {32'd0, price}) * 64'd2 / 64'(p + 1);
    return base - step[FIELD_W-1:0];
  endfunction

  function automatic void advance_average(input logic [FIELD_W-1:0] price,
                                          input logic restart);
    int unsigned        p;
    ema_res_t           r;
    logic [FIELD_W-1:0] sma;
    p = smoothing_period();
    if (restart) begin
      seed_acc   = '0;
      seen_cnt   = '0;
      avg_seeded = 1'b0;
      last_avg   = '0;
    end
    if (avg_seeded) begin
      last_avg = smoothed(last_avg, price, p);
      r.value  = last_avg;
      r.avail  = 1'b1;
    end else if (seen_cnt >= p && seen_cnt != '0) begin
      sma        = FIELD_W'(seed_acc / {31'd0, seen_cnt});
      last_avg   = smoothed(sma, price, p);
      avg_seeded = 1'b1;
      r.value    = last_avg;
      r.avail    = 1'b1;
    end else begin
      seed_acc = seed_acc + {6'd0, price};
      seen_cnt = seen_cnt + 7'd1;
      r.value  = '0;
      r.avail  = 1'b0;
    end
    ema_due_q.insert(ema_due_q.size(), r);
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin : drv_proc
    price_item_t it;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      close_price_i <= '0;
      restart_i     <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        advance_average(close_price_i, restart_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (price_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          it = price_q.pop_front();
          in_valid_i    <= 1'b1;
          close_price_i <= it.price;
          restart_i     <= it.restart;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : mon_proc
    ema_res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (ema_due_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, actual ema_value %h valid_res %b",
                   $time, ema_value_o, valid_res_o);
        end else begin
          want = ema_due_q.pop_front();
          if (ema_value_o !== want.value) begin
            err_count++;
            $display("%0t: ema_value expected %h actual %h", $time, want.value, ema_value_o);
          end
          if (valid_res_o !== want.avail) begin
            err_count++;
            $display("%0t: valid_res expected %b actual %b", $time, want.avail, valid_res_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic push_price(input logic [FIELD_W-1:0] price, input logic restart);
    price_item_t it;
    it.price   = price;
    it.restart = restart;
    price_q.insert(price_q.size(), it);
  endtask

  task automatic settle();
    while (price_q.size() != 0 || in_valid_i || ema_due_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] v);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    period_reg = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [FIELD_W-1:0] pick_price(input int mode,
                                                     input logic [FIELD_W-1:0] centre);
    case (mode)
      0:       return $urandom;
      1:       return centre + FIELD_W'($urandom_range(2047)) - 32'd1024;
      2:       return $urandom_range(1) ? '1 : '0;
      default: return FIELD_W'($urandom_range(65535));
    endcase
  endfunction

  initial begin : stim_proc
    int                  total;
    int                  phase;
    int                  target;
    int                  n;
    int                  len;
    int                  mode;
    int                  r;
    int unsigned         p;
    logic [PERIOD_W-1:0] pv;
    logic [FIELD_W-1:0]  centre;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset period: full-scale prices through the seed, then a drop to zero
    for (int i = 0; i < 13; i++) push_price('1, i == 0);
    push_price('0, 1'b0);
    // period lowered before the seed: mean of the five summed prices
    push_price(32'h0001_0000, 1'b1);
    for (int i = 0; i < 4; i++) push_price(32'h0003_8000 + 32'(i * 'h1_0000), 1'b0);
    write_period(7'd3);
    push_price(32'h0010_0000, 1'b0);
    push_price(32'h0000_0001, 1'b0);
    // period zero behaves as one
    write_period(7'd0);
    push_price(32'h8000_0000, 1'b1);
    push_price(32'h0000_0000, 1'b0);
    push_price(32'hFFFF_FFFF, 1'b0);

    total = 0;
    phase = 0;
    while (total < N_ITEMS) begin
      r = $urandom_range(99);
      case (phase)
        0:       pv = 7'd64;
        1:       pv = 7'd127;
        2:       pv = 7'd1;
        default: begin
          if (r < 8)       pv = 7'd0;
          else if (r < 16) pv = 7'd1;
          else if (r < 22) pv = 7'd64;
          else if (r < 27) pv = PERIOD_W'($urandom_range(127, 65));
          else if (r < 38) pv = PERIOD_W'($urandom_range(63, 17));
          else             pv = PERIOD_W'($urandom_range(16, 2));
        end
      endcase
      write_period(pv);
      idle_pct = (phase == 4) ? 0 : 33;
      p = smoothing_period();
      target = (phase == 4) ? 200 : $urandom_range(120, 40);
      n = 0;
      while (n < target) begin
        mode   = $urandom_range(3);
        centre = $urandom;
        if ($urandom_range(9) < 8) len = p + $urandom_range(30, 1);
        else                       len = $urandom_range(p + 1, 1);
        for (int i = 0; i < len; i++) begin
          push_price(pick_price(mode, centre),
                     (i == 0 && $urandom_range(9) != 0) || $urandom_range(49) == 0);
          if (mode == 1) centre = centre + FIELD_W'($urandom_range(4095)) - 32'd2048;
        end
        n += len;
      end
      total += n;
      phase++;
    end

    settle();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : timeout_proc
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
